// File: src/csp_pkg.sv
// shared types and constants for the circle symmetry point expander
// no dependencies; used by every module of the block by scoped names
package csp_pkg;

    localparam int COORD_BITS = 16;
    localparam int NUM_CAND   = 8;
    localparam int SEL_BITS   = $clog2(NUM_CAND);
    localparam int CFG_IDX_BITS = 2;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_WINDOW_LEFT   = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_WINDOW_TOP    = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_WINDOW_RIGHT  = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_WINDOW_BOTTOM = t_cfg_idx'(3);

    localparam t_coord WINDOW_LOW_RESET  = '0;
    localparam t_coord WINDOW_HIGH_RESET = t_coord'(65535);

    typedef struct packed {
        t_coord center_x;
        t_coord center_y;
        t_coord offset_i;
        t_coord offset_j;
    } t_in_req;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        logic   last_point;
    } t_out_req;

    typedef struct packed {
        t_coord left;
        t_coord top;
        t_coord right;
        t_coord bottom;
    } t_window;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef struct packed {
        logic [NUM_CAND-1:0]   mask;
        t_point [NUM_CAND-1:0] pts;
    } t_cand_set;

endpackage

// File: src/csp_eval.sv
// candidate point generation and window test for one registered request
// depends on csp_pkg
module csp_eval (
    input  csp_pkg::t_in_req   i_req,
    input  csp_pkg::t_window   i_window,
    output csp_pkg::t_cand_set o_cands
);

    typedef struct packed {
        logic            ok;
        csp_pkg::t_coord val;
    } t_coord_ok;

    function automatic t_coord_ok add_c(csp_pkg::t_coord a, csp_pkg::t_coord b);
        logic [csp_pkg::COORD_BITS:0] s;
        t_coord_ok r;
        s = {1'b0, a} + {1'b0, b};
        r.ok  = ~s[csp_pkg::COORD_BITS];
        r.val = s[csp_pkg::COORD_BITS-1:0];
        return r;
    endfunction

    function automatic t_coord_ok sub_c(csp_pkg::t_coord a, csp_pkg::t_coord b);
        logic [csp_pkg::COORD_BITS:0] s;
        t_coord_ok r;
        s = {1'b0, a} - {1'b0, b};
        r.ok  = ~s[csp_pkg::COORD_BITS];
        r.val = s[csp_pkg::COORD_BITS-1:0];
        return r;
    endfunction

    t_coord_ok xpi, xmi, xpj, xmj, ypi, ymi, ypj, ymj, x0, y0;
    t_coord_ok xpd, xmd, ypd, ymd;
    t_coord_ok cand_x [csp_pkg::NUM_CAND];
    t_coord_ok cand_y [csp_pkg::NUM_CAND];
    logic [csp_pkg::NUM_CAND-1:0] used;
    logic zero_i, zero_j;

    always_comb begin
        xpi = add_c(i_req.center_x, i_req.offset_i);
        xmi = sub_c(i_req.center_x, i_req.offset_i);
        xpj = add_c(i_req.center_x, i_req.offset_j);
        xmj = sub_c(i_req.center_x, i_req.offset_j);
        ypi = add_c(i_req.center_y, i_req.offset_i);
        ymi = sub_c(i_req.center_y, i_req.offset_i);
        ypj = add_c(i_req.center_y, i_req.offset_j);
        ymj = sub_c(i_req.center_y, i_req.offset_j);
        x0  = {1'b1, i_req.center_x};
        y0  = {1'b1, i_req.center_y};
        zero_i = (i_req.offset_i == '0);
        zero_j = (i_req.offset_j == '0);
        xpd = zero_i ? xpj : xpi;
        xmd = zero_i ? xmj : xmi;
        ypd = zero_i ? ypj : ypi;
        ymd = zero_i ? ymj : ymi;

        for (int k = 0; k < csp_pkg::NUM_CAND; k++) begin
            cand_x[k] = x0;
            cand_y[k] = y0;
        end
        used = '0;

        if (zero_i && zero_j) begin
            used = csp_pkg::NUM_CAND'(1);
        end else if (zero_i || zero_j) begin
            used = csp_pkg::NUM_CAND'(4'hF);
            cand_x[0] = xpd;
            cand_x[1] = xmd;
            cand_y[2] = ypd;
            cand_y[3] = ymd;
        end else if (i_req.offset_i == i_req.offset_j) begin
            used = csp_pkg::NUM_CAND'(4'hF);
            cand_x[0] = xpi; cand_y[0] = ypi;
            cand_x[1] = xmi; cand_y[1] = ypi;
            cand_x[2] = xpi; cand_y[2] = ymi;
            cand_x[3] = xmi; cand_y[3] = ymi;
        end else begin
            used = '1;
            cand_x[0] = xpi; cand_y[0] = ypj;
            cand_x[1] = xmi; cand_y[1] = ypj;
            cand_x[2] = xpi; cand_y[2] = ymj;
            cand_x[3] = xmi; cand_y[3] = ymj;
            cand_x[4] = xpj; cand_y[4] = ypi;
            cand_x[5] = xmj; cand_y[5] = ypi;
            cand_x[6] = xpj; cand_y[6] = ymi;
            cand_x[7] = xmj; cand_y[7] = ymi;
        end

        for (int k = 0; k < csp_pkg::NUM_CAND; k++) begin
            o_cands.pts[k].x = cand_x[k].val;
            o_cands.pts[k].y = cand_y[k].val;
            o_cands.mask[k]  = used[k] && cand_x[k].ok && cand_y[k].ok
                            && (cand_x[k].val >= i_window.left)
                            && (cand_x[k].val <= i_window.right)
                            && (cand_y[k].val >= i_window.top)
                            && (cand_y[k].val <= i_window.bottom);
        end
    end

endmodule

// File: src/csp_emit.sv
// candidate buffer and output register: hands out in-window points in order
// depends on csp_pkg
module csp_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  csp_pkg::t_cand_set i_cands,
    output logic               o_take,
    output logic               o_valid,
    input  logic               i_stall,
    output csp_pkg::t_out_req  o_out
);

    logic [csp_pkg::NUM_CAND-1:0]   r_mask, n_mask;
    csp_pkg::t_point [csp_pkg::NUM_CAND-1:0] r_pts;
    logic                           r_valid;
    csp_pkg::t_out_req              r_out;

    logic [csp_pkg::SEL_BITS-1:0]   sel;
    logic [csp_pkg::NUM_CAND-1:0]   rest;
    logic                           advance, last;

    always_comb begin
        sel = '0;
        for (int k = csp_pkg::NUM_CAND - 1; k >= 0; k--) begin
            if (r_mask[k]) sel = csp_pkg::SEL_BITS'(k);
        end
        rest    = r_mask & ~(csp_pkg::NUM_CAND'(1) << sel);
        last    = (rest == '0);
        advance = (r_mask != '0) && (!r_valid || !i_stall);
        o_take  = (r_mask == '0) || (advance && last);
        n_mask  = advance ? rest : r_mask;
        if (i_load && o_take) n_mask = i_cands.mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (advance) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
        if (i_load && o_take) r_pts <= i_cands.pts;
        if (advance) begin
            r_out.point_x    <= r_pts[sel].x;
            r_out.point_y    <= r_pts[sel].y;
            r_out.last_point <= last;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

// File: src/circle_symmetry_point_expander_top.sv
// circle symmetry point expander: each request carries a centre and an offset pair and
// yields its mirrored points that fall inside the configured window, one point per
// cycle while the output is not stalled, the last one flagged; a request holds the point
// buffer until all its in-window points (up to 8) are handed out, and the next request
// is loaded into the buffer as the last point of the one before is handed out
// depends on csp_pkg, csp_eval, csp_emit
module circle_symmetry_point_expander_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  csp_pkg::t_in_req  i_in,
    output logic              o_valid,
    input  logic              i_stall,
    output csp_pkg::t_out_req o_out,
    input  logic              i_cfg_we,
    input  csp_pkg::t_cfg_idx i_cfg_idx,
    input  csp_pkg::t_coord   i_cfg_data
);

    csp_pkg::t_window   r_window;
    csp_pkg::t_in_req   r_in;
    logic               r_in_valid;
    csp_pkg::t_cand_set cands;
    logic               take;
    logic               accept;

    assign o_stall = r_in_valid && !take;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window.left   <= csp_pkg::WINDOW_LOW_RESET;
            r_window.top    <= csp_pkg::WINDOW_LOW_RESET;
            r_window.right  <= csp_pkg::WINDOW_HIGH_RESET;
            r_window.bottom <= csp_pkg::WINDOW_HIGH_RESET;
            r_in_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    csp_pkg::CFG_WINDOW_LEFT:   r_window.left   <= i_cfg_data;
                    csp_pkg::CFG_WINDOW_TOP:    r_window.top    <= i_cfg_data;
                    csp_pkg::CFG_WINDOW_RIGHT:  r_window.right  <= i_cfg_data;
                    csp_pkg::CFG_WINDOW_BOTTOM: r_window.bottom <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end
        end
        if (accept) r_in <= i_in;
    end

    csp_eval u_eval (
        .i_req    (r_in),
        .i_window (r_window),
        .o_cands  (cands)
    );

    csp_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_in_valid),
        .i_cands (cands),
        .o_take  (take),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

endmodule

// File: tb/circle_symmetry_point_checker.sv
// checker for the circle symmetry point expander: predicts the in-window mirrored points of
// every accepted request and compares each accepted output point against them in order
// depends on csp_pkg; instantiated beside the block by circle_symmetry_point_expander_top_tb
`timescale 1ns / 1ps

module circle_symmetry_point_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  csp_pkg::t_in_req  i_in,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  csp_pkg::t_out_req i_out,
    input  logic              i_cfg_we,
    input  csp_pkg::t_cfg_idx i_cfg_idx,
    input  csp_pkg::t_coord   i_cfg_data,
    output int                o_mismatches,
    output int                o_points_pending,
    output int                o_requests,
    output int                o_points_checked
);
    import csp_pkg::*;

    localparam longint COORD_MAX = (longint'(1) << COORD_BITS) - 1;

    longint   win_left;
    longint   win_top;
    longint   win_right;
    longint   win_bottom;
    t_out_req expected_points[$];
    t_out_req mirrored_points[$];

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        o_mismatches++;
    endtask

    function automatic void offer_point(input longint x, input longint y);
        t_out_req pt;
        if (x < 0 || y < 0 || x > COORD_MAX || y > COORD_MAX) return;
        if (x < win_left || x > win_right || y < win_top || y > win_bottom) return;
        pt.point_x    = t_coord'(x);
        pt.point_y    = t_coord'(y);
        pt.last_point = 1'b0;
        mirrored_points.push_back(pt);
    endfunction

    function automatic void expand_request(input t_in_req req);
        longint   cx;
        longint   cy;
        longint   oi;
        longint   oj;
        longint   d;
        t_out_req pt;
        cx = longint'(req.center_x);
        cy = longint'(req.center_y);
        oi = longint'(req.offset_i);
        oj = longint'(req.offset_j);
        mirrored_points.delete();
        if (oi == 0 && oj == 0) begin
            offer_point(cx, cy);
        end else if (oi == 0 || oj == 0) begin
            d = (oi == 0) ? oj : oi;
            offer_point(cx + d, cy);
            offer_point(cx - d, cy);
            offer_point(cx, cy + d);
            offer_point(cx, cy - d);
        end else if (oi == oj) begin
            offer_point(cx + oi, cy + oi);
            offer_point(cx - oi, cy + oi);
            offer_point(cx + oi, cy - oi);
            offer_point(cx - oi, cy - oi);
        end else begin
            offer_point(cx + oi, cy + oj);
            offer_point(cx - oi, cy + oj);
            offer_point(cx + oi, cy - oj);
            offer_point(cx - oi, cy - oj);
            offer_point(cx + oj, cy + oi);
            offer_point(cx - oj, cy + oi);
            offer_point(cx + oj, cy - oi);
            offer_point(cx - oj, cy - oi);
        end
        foreach (mirrored_points[k]) begin
            pt = mirrored_points[k];
            pt.last_point = (k == mirrored_points.size() - 1);
            expected_points.push_back(pt);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            win_left   = longint'(WINDOW_LOW_RESET);
            win_top    = longint'(WINDOW_LOW_RESET);
            win_right  = longint'(WINDOW_HIGH_RESET);
            win_bottom = longint'(WINDOW_HIGH_RESET);
            expected_points.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW_LEFT:   win_left   = longint'(i_cfg_data);
                    CFG_WINDOW_TOP:    win_top    = longint'(i_cfg_data);
                    CFG_WINDOW_RIGHT:  win_right  = longint'(i_cfg_data);
                    CFG_WINDOW_BOTTOM: win_bottom = longint'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_points.size() == 0) begin
                    report_mismatch($sformatf("point (%0d,%0d) with nothing expected",
                                              i_out.point_x, i_out.point_y));
                end else begin
                    want = expected_points.pop_front();
                    o_points_checked++;
                    if (i_out.point_x !== want.point_x)
                        report_mismatch($sformatf("point_x %0d, expected %0d",
                                                  i_out.point_x, want.point_x));
                    if (i_out.point_y !== want.point_y)
                        report_mismatch($sformatf("point_y %0d, expected %0d",
                                                  i_out.point_y, want.point_y));
                    if (i_out.last_point !== want.last_point)
                        report_mismatch($sformatf("last_point %0b, expected %0b",
                                                  i_out.last_point, want.last_point));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                o_requests++;
                expand_request(i_in);
            end
        end
        o_points_pending <= expected_points.size();
    end

endmodule

// File: tb/circle_symmetry_point_expander_top_tb.sv
// testbench top for the circle symmetry point expander: clock, reset, window writes,
// directed and random requests, random output stalls, watchdog and verdict
// depends on csp_pkg, circle_symmetry_point_expander_top and circle_symmetry_point_checker
`timescale 1ns / 1ps

module circle_symmetry_point_expander_top_tb;
    import csp_pkg::*;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_PER_PHASE = 44;
    localparam int NUM_PHASES       = 9;
    localparam int SETTLE_CYCLES    = 4;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_req   i_in;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_req  o_out;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_idx;
    t_coord    i_cfg_data;

    int        mismatches;
    int        points_pending;
    int        requests;
    int        points_checked;
    int        idle_cycles;
    int        stall_left;
    bit        quiet;
    t_window   cur_win;

    circle_symmetry_point_expander_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    circle_symmetry_point_checker point_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_in             (i_in),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_out            (o_out),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_mismatches     (mismatches),
        .o_points_pending (points_pending),
        .o_requests       (requests),
        .o_points_checked (points_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    // output back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) stall_left = gap_length();
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input t_in_req req);
        int gap;
        gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : gap_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= req;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic send_coords(input t_coord cx, input t_coord cy,
                               input t_coord oi, input t_coord oj);
        send_request('{center_x: cx, center_y: cy, offset_i: oi, offset_j: oj});
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (points_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_window(input t_window w);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WINDOW_LEFT;
        i_cfg_data <= w.left;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_WINDOW_TOP;
        i_cfg_data <= w.top;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_WINDOW_RIGHT;
        i_cfg_data <= w.right;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_WINDOW_BOTTOM;
        i_cfg_data <= w.bottom;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic t_window random_window(input int max_span);
        t_window w;
        int      lo;
        lo       = $urandom_range(0, 65535);
        w.left   = t_coord'(lo);
        w.right  = t_coord'((lo + max_span > 65535) ? 65535 : lo + $urandom_range(0, max_span));
        lo       = $urandom_range(0, 65535);
        w.top    = t_coord'(lo);
        w.bottom = t_coord'((lo + max_span > 65535) ? 65535 : lo + $urandom_range(0, max_span));
        return w;
    endfunction

    function automatic t_in_req make_request(input t_window w);
        t_in_req req;
        bit      wide;
        if ($urandom_range(0, 4) == 0 || w.left > w.right || w.top > w.bottom) begin
            req.center_x = t_coord'($urandom);
            req.center_y = t_coord'($urandom);
        end else begin
            req.center_x = t_coord'($urandom_range(w.left, w.right));
            req.center_y = t_coord'($urandom_range(w.top, w.bottom));
        end
        if ($urandom_range(0, 19) == 0) req.center_x = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 19) == 0) req.center_y = $urandom_range(0, 1) ? '1 : '0;
        wide = ($urandom_range(0, 4) == 0);
        req.offset_i = wide ? t_coord'($urandom) : t_coord'($urandom_range(0, 200));
        req.offset_j = wide ? t_coord'($urandom) : t_coord'($urandom_range(0, 200));
        case ($urandom_range(0, 9))
            0: begin
                req.offset_i = '0;
                req.offset_j = '0;
            end
            1: req.offset_i = '0;
            2: req.offset_j = '0;
            3: req.offset_j = req.offset_i;
            default: ;
        endcase
        return req;
    endfunction

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_in       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_WINDOW_LEFT;
        i_cfg_data = '0;
        quiet      = 1'b0;
        cur_win    = '{left: WINDOW_LOW_RESET, top: WINDOW_LOW_RESET,
                       right: WINDOW_HIGH_RESET, bottom: WINDOW_HIGH_RESET};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset window, every offset shape and the coordinate extremes
        send_coords(16'd0, 16'd0, 16'd0, 16'd0);
        send_coords(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        send_coords(16'd100, 16'd100, 16'd0, 16'd5);
        send_coords(16'd100, 16'd100, 16'd7, 16'd0);
        send_coords(16'd100, 16'd100, 16'd9, 16'd9);
        send_coords(16'd100, 16'd100, 16'd3, 16'd11);
        send_coords(16'd0, 16'd0, 16'd3, 16'd11);
        send_coords(16'hFFFF, 16'hFFFF, 16'd3, 16'd11);
        send_coords(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        send_coords(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_coords(16'h8000, 16'h8000, 16'hFFFF, 16'd1);
        send_coords(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        send_coords(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
        send_coords(16'd1, 16'd1, 16'd1, 16'd2);
        send_coords(16'h5555, 16'hAAAA, 16'h00FF, 16'h0F0F);
        send_coords(16'hAAAA, 16'h5555, 16'hFF00, 16'hF0F0);
        drain();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: cur_win = '{left: 16'd0, top: 16'd0, right: 16'hFFFF, bottom: 16'hFFFF};
                1: cur_win = '{left: 16'd1000, top: 16'd2000, right: 16'd1200, bottom: 16'd2300};
                2: cur_win = '{left: 16'd0, top: 16'd0, right: 16'd100, bottom: 16'd100};
                3: cur_win = '{left: 16'd65435, top: 16'd65435,
                               right: 16'hFFFF, bottom: 16'hFFFF};
                4: cur_win = '{left: 16'd500, top: 16'd0, right: 16'd400, bottom: 16'hFFFF};
                5: cur_win = '{left: 16'd0, top: 16'd700, right: 16'hFFFF, bottom: 16'd600};
                6: cur_win = '{left: 16'd300, top: 16'd300, right: 16'd300, bottom: 16'd300};
                default: cur_win = random_window(400);
            endcase
            quiet = (phase == 0 || phase == 7);
            write_window(cur_win);
            @(negedge i_clk);
            repeat (RANDOM_PER_PHASE) send_request(make_request(cur_win));
            drain();
        end
        quiet = 1'b0;
        repeat (8) @(posedge i_clk);

        $display("run covered %0d requests under %0d window settings, %0d points checked",
                 requests, NUM_PHASES + 1, points_checked);
        if (mismatches == 0 && points_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
